// ===== rtl/core/maze_backtracker_carver_assert.svh =====
// ----------------------------------------------------------------------------
// maze_backtracker_carver_assert.svh
// assertion macros used by the maze carver rtl
// ----------------------------------------------------------------------------
`ifndef MAZE_BACKTRACKER_CARVER_ASSERT_SVH
`define MAZE_BACKTRACKER_CARVER_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst is high
`define MBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("maze carver assertion failed");

// next-cycle implication, checked on clk, off while rst is high
`define MBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("maze carver assertion failed");

`endif

// ===== rtl/core/mbc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbc_pkg
// types, codes and constants of the maze carver
// ----------------------------------------------------------------------------
package mbc_pkg;

  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned MAX_HEIGHT = 64;
  localparam int unsigned CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned WALL_W     = 4;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_CARVED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_FINISHED = 3'd2,
    ST_READ     = 3'd3,
    ST_STARTED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_START  = 2'd2,
    CFG_END    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    req_t               req_type;
    dir_t               direction;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } mbc_in_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [WALL_W-1:0]  walls;
    logic [COUNT_W-1:0] path_depth;
  } mbc_out_t;

  // wall bit opened in the cell we leave
  function automatic logic [WALL_W-1:0] side_bit(dir_t d);
    logic [WALL_W-1:0] b;
    case (d)
      DIR_LEFT:  b = 4'b1000;
      DIR_DOWN:  b = 4'b0001;
      DIR_RIGHT: b = 4'b0010;
      DIR_UP:    b = 4'b0100;
      default:   b = 4'b0000;
    endcase
    return b;
  endfunction

  // wall bit opened in the cell we enter
  function automatic logic [WALL_W-1:0] back_bit(dir_t d);
    logic [WALL_W-1:0] b;
    case (d)
      DIR_LEFT:  b = 4'b0010;
      DIR_DOWN:  b = 4'b0100;
      DIR_RIGHT: b = 4'b1000;
      DIR_UP:    b = 4'b0001;
      default:   b = 4'b0000;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/mbc_ram.sv =====
// ----------------------------------------------------------------------------
// mbc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/maze_backtracker_carver.sv =====
// ----------------------------------------------------------------------------
// maze_backtracker_carver
// randomized depth-first maze carver with a wall grid and a path stack in ram
// ----------------------------------------------------------------------------
// The block carves a maze of up to 64 x 64 cells one step per request. A start
// request clears the wall grid and puts the walker on the bottom row; each step
// request brings a random direction, backtracks along the path stack until the
// walker has an unvisited neighbor, then opens the walls toward that direction
// if the move is legal. Read requests return one cell's open sides. The wall
// grid (4096 x 4) and the path stack (4096 x 12) sit in two rams with one write
// and one registered read port each, and one request is worked at a time. A
// step reads the walker's cell and its four neighbors through the single grid
// read port, decides, makes two grid writes to carve and hands off the result.
// Every backtrack pop adds a stack read plus a new neighbor scan. Read requests
// and unused request codes go through the same cell scan and decide. A start
// request clears the grid one entry per cycle; the same clearing pass runs
// after reset, with in_ready low, while config writes are taken as usual. A
// result waits in the output register, so the next request is taken while it
// is still unclaimed.
// ----------------------------------------------------------------------------
`include "maze_backtracker_carver_assert.svh"

module maze_backtracker_carver (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mbc_pkg::mbc_in_t                     in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mbc_pkg::mbc_out_t                    out_data,
  // config write port
  input  logic                                 cfg_wr_en,
  input  logic [mbc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mbc_pkg::SIZE_W-1:0]           cfg_wdata
);

  localparam int unsigned CW = mbc_pkg::COORD_W;
  localparam int unsigned SW = mbc_pkg::SIZE_W;
  localparam int unsigned IW = mbc_pkg::IDX_W;
  localparam int unsigned NW = mbc_pkg::COUNT_W;
  localparam int unsigned WW = mbc_pkg::WALL_W;

  typedef enum logic [7:0] {
    S_IDLE        = 8'b0000_0001,
    S_CLEAR       = 8'b0000_0010,
    S_SCAN        = 8'b0000_0100,
    S_EVAL        = 8'b0000_1000,
    S_POP_WAIT    = 8'b0001_0000,
    S_CARVE_HERE  = 8'b0010_0000,
    S_CARVE_THERE = 8'b0100_0000,
    S_RESULT      = 8'b1000_0000
  } state_t;

  state_t state;

  // config registers
  logic [SW-1:0] width;
  logic [SW-1:0] height;
  logic [CW-1:0] start_x;
  logic [CW-1:0] end_x;

  // walker and stack control
  logic [CW-1:0] walker_x;
  logic [CW-1:0] walker_y;
  logic [NW-1:0] count;
  logic          finished;

  // request held for the duration of the work
  mbc_pkg::req_t req_q;
  mbc_pkg::dir_t dir_q;
  logic [CW-1:0] cx_q;
  logic [CW-1:0] cy_q;

  // scan results
  logic [2:0]    probe;
  logic [WW-1:0] here_val;
  logic [3:0]    free;

  // clearing pass
  logic [IW-1:0] clr_addr;
  logic          clr_from_start;

  mbc_pkg::mbc_out_t res;

  // ram ports
  logic          grid_we;
  logic [IW-1:0] grid_waddr;
  logic [WW-1:0] grid_wdata;
  logic [IW-1:0] grid_raddr;
  logic [WW-1:0] grid_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [IW-1:0] stk_wdata;
  logic [IW-1:0] stk_raddr;
  logic [IW-1:0] stk_rdata;

  // effective sizes
  logic [SW-1:0] eff_w;
  logic [SW-1:0] eff_h;
  logic [CW-1:0] eff_end;
  logic [CW-1:0] start_sat;
  logic [CW-1:0] start_y;

  // neighbor geometry, one lane per direction
  logic [SW-1:0] nbr_x   [4];
  logic [SW-1:0] nbr_y   [4];
  logic [3:0]    nbr_in;
  logic [IW-1:0] nbr_idx [4];

  logic          in_xfer;
  logic          here_is_end;
  logic          has_open;
  logic [NW-1:0] count_dec;
  logic          tgt_is_end;
  logic          read_in;
  logic          push_ok;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // sizes clamped to 1..64, start and end columns kept below width
  always_comb begin
    if (width == '0) begin
      eff_w = SW'(1);
    end else if (width > SW'(mbc_pkg::MAX_WIDTH)) begin
      eff_w = SW'(mbc_pkg::MAX_WIDTH);
    end else begin
      eff_w = width;
    end
    if (height == '0) begin
      eff_h = SW'(1);
    end else if (height > SW'(mbc_pkg::MAX_HEIGHT)) begin
      eff_h = SW'(mbc_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height;
    end
    eff_end   = ({1'b0, end_x} < eff_w) ? end_x : CW'(eff_w - SW'(1));
    start_sat = ({1'b0, start_x} < eff_w) ? start_x : CW'(eff_w - SW'(1));
    start_y   = CW'(eff_h - SW'(1));
  end

  // the four neighbors of the walker, with an on-grid flag each
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      logic under;
      under    = 1'b0;
      nbr_x[d] = {1'b0, walker_x};
      nbr_y[d] = {1'b0, walker_y};
      case (mbc_pkg::dir_t'(d))
        mbc_pkg::DIR_LEFT: begin
          under    = (walker_x == '0);
          nbr_x[d] = {1'b0, walker_x} - SW'(1);
        end
        mbc_pkg::DIR_DOWN: begin
          nbr_y[d] = {1'b0, walker_y} + SW'(1);
        end
        mbc_pkg::DIR_RIGHT: begin
          nbr_x[d] = {1'b0, walker_x} + SW'(1);
        end
        mbc_pkg::DIR_UP: begin
          under    = (walker_y == '0);
          nbr_y[d] = {1'b0, walker_y} - SW'(1);
        end
        default: begin
          under = 1'b1;
        end
      endcase
      nbr_in[d]  = !under && (nbr_x[d] < eff_w) && (nbr_y[d] < eff_h);
      nbr_idx[d] = {nbr_y[d][CW-1:0], nbr_x[d][CW-1:0]};
    end
  end

  assign here_is_end = (walker_x == eff_end) && (walker_y == '0);
  assign has_open    = !here_is_end && (free != '0);
  assign count_dec   = (count != '0) ? count - NW'(1) : count;
  assign tgt_is_end  = (nbr_x[dir_q] == {1'b0, eff_end}) && (nbr_y[dir_q] == '0);
  assign read_in     = ({1'b0, cx_q} < eff_w) && ({1'b0, cy_q} < eff_h);
  assign push_ok     = (count < NW'(mbc_pkg::CELLS));

  // grid read address: probe 0 is the walker's own cell (or the read cell),
  // probes 1 to 4 are the neighbors left, down, right, up
  always_comb begin
    case (probe)
      3'd1:    grid_raddr = nbr_idx[0];
      3'd2:    grid_raddr = nbr_idx[1];
      3'd3:    grid_raddr = nbr_idx[2];
      3'd4:    grid_raddr = nbr_idx[3];
      default: grid_raddr = (req_q == mbc_pkg::REQ_READ) ? {cy_q, cx_q}
                                                         : {walker_y, walker_x};
    endcase
  end

  // grid writes: clearing pass, then the two halves of a carve
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = clr_addr;
    grid_wdata = '0;
    case (state)
      S_CLEAR: begin
        grid_we = 1'b1;
      end
      S_CARVE_HERE: begin
        grid_we    = 1'b1;
        grid_waddr = {walker_y, walker_x};
        grid_wdata = here_val | mbc_pkg::side_bit(dir_q);
      end
      S_CARVE_THERE: begin
        grid_we    = 1'b1;
        grid_waddr = nbr_idx[dir_q];
        grid_wdata = mbc_pkg::back_bit(dir_q);
      end
      default: begin
        grid_we = 1'b0;
      end
    endcase
  end

  // stack: the start cell goes in at the transfer, new cells on a carve
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = count[IW-1:0];
    stk_wdata = nbr_idx[dir_q];
    if (in_xfer && (in_data.req_type == mbc_pkg::REQ_START)) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {start_y, start_sat};
    end else if ((state == S_CARVE_THERE) && !tgt_is_end && push_ok) begin
      stk_we = 1'b1;
    end
  end

  // new top of stack after a pop, read in the decide cycle
  assign stk_raddr = IW'(count_dec - NW'(1));

  mbc_ram #(
    .WIDTH(mbc_pkg::WALL_W),
    .DEPTH(mbc_pkg::CELLS)
  ) u_grid (
    .clk  (clk),
    .we   (grid_we),
    .waddr(grid_waddr),
    .wdata(grid_wdata),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  mbc_ram #(
    .WIDTH(mbc_pkg::IDX_W),
    .DEPTH(mbc_pkg::CELLS)
  ) u_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(stk_wdata),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  // config writes, taken at any time
  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= SW'(16);
      height  <= SW'(16);
      start_x <= '0;
      end_x   <= CW'(15);
    end else if (cfg_wr_en) begin
      case (mbc_pkg::cfg_reg_t'(cfg_index))
        mbc_pkg::CFG_WIDTH:  width   <= cfg_wdata;
        mbc_pkg::CFG_HEIGHT: height  <= cfg_wdata;
        mbc_pkg::CFG_START:  start_x <= cfg_wdata[CW-1:0];
        mbc_pkg::CFG_END:    end_x   <= cfg_wdata[CW-1:0];
        default:             width   <= width;
      endcase
    end
  end

  // request latch and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_q <= in_data.req_type;
      dir_q <= in_data.direction;
      cx_q  <= in_data.cell_x;
      cy_q  <= in_data.cell_y;
    end
    // capture the read that was issued in the previous cycle
    if (state == S_SCAN) begin
      case (probe)
        3'd1:    here_val <= grid_rdata;
        3'd2:    free[0]  <= nbr_in[0] && (grid_rdata == '0);
        3'd3:    free[1]  <= nbr_in[1] && (grid_rdata == '0);
        3'd4:    free[2]  <= nbr_in[2] && (grid_rdata == '0);
        3'd5:    free[3]  <= nbr_in[3] && (grid_rdata == '0);
        default: here_val <= here_val;
      endcase
    end
    if (in_xfer && (in_data.req_type == mbc_pkg::REQ_START)) begin
      res <= '{status: mbc_pkg::ST_STARTED, pos_x: start_sat, pos_y: start_y,
               walls: '0, path_depth: NW'(1)};
    end else if (state == S_EVAL) begin
      res <= '{status: mbc_pkg::ST_REJECTED, pos_x: walker_x, pos_y: walker_y,
               walls: here_val, path_depth: count};
      case (req_q)
        mbc_pkg::REQ_READ: begin
          res <= '{status: mbc_pkg::ST_READ, pos_x: cx_q, pos_y: cy_q,
                   walls: read_in ? here_val : '0, path_depth: count};
        end
        mbc_pkg::REQ_STEP: begin
          if (finished) begin
            res.status <= mbc_pkg::ST_FINISHED;
          end else if (!has_open) begin
            // only reaches the result when the stack ran dry
            res.status     <= mbc_pkg::ST_FINISHED;
            res.path_depth <= count_dec;
          end
        end
        default: begin
          res.status <= mbc_pkg::ST_REJECTED;
        end
      endcase
    end else if (state == S_CARVE_THERE) begin
      res.status <= mbc_pkg::ST_CARVED;
      if (tgt_is_end) begin
        // the end cell is a leaf: the walker stays put
        res.pos_x      <= walker_x;
        res.pos_y      <= walker_y;
        res.walls      <= here_val | mbc_pkg::side_bit(dir_q);
        res.path_depth <= count;
      end else begin
        res.pos_x      <= nbr_x[dir_q][CW-1:0];
        res.pos_y      <= nbr_y[dir_q][CW-1:0];
        res.walls      <= mbc_pkg::back_bit(dir_q);
        res.path_depth <= push_ok ? count + NW'(1) : count;
      end
    end
  end

  // output register, freed by a transfer on the result side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESULT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESULT) && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

  // sequencer and walker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      clr_from_start <= 1'b0;
      probe          <= '0;
      walker_x       <= '0;
      walker_y       <= '0;
      count          <= '0;
      finished       <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          probe <= '0;
          if (in_xfer) begin
            if (in_data.req_type == mbc_pkg::REQ_START) begin
              walker_x       <= start_sat;
              walker_y       <= start_y;
              count          <= NW'(1);
              finished       <= 1'b0;
              clr_addr       <= '0;
              clr_from_start <= 1'b1;
              state          <= S_CLEAR;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + IW'(1);
          if (clr_addr == IW'(mbc_pkg::CELLS - 1)) begin
            state <= clr_from_start ? S_RESULT : S_IDLE;
          end
        end
        S_SCAN: begin
          // probes 0..4 issued, each read's data lands in the next cycle
          probe <= probe + 3'd1;
          if (probe == 3'd5) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          probe <= '0;
          state <= S_RESULT;
          if ((req_q == mbc_pkg::REQ_STEP) && !finished) begin
            if (!has_open) begin
              count <= count_dec;
              if (count_dec == '0) begin
                finished <= 1'b1;
              end else begin
                state <= S_POP_WAIT;
              end
            end else if (free[dir_q]) begin
              state <= S_CARVE_HERE;
            end
          end
        end
        S_POP_WAIT: begin
          // backtrack to the new top of stack and scan again
          walker_x <= stk_rdata[CW-1:0];
          walker_y <= stk_rdata[IW-1:CW];
          state    <= S_SCAN;
        end
        S_CARVE_HERE: begin
          state <= S_CARVE_THERE;
        end
        S_CARVE_THERE: begin
          if (!tgt_is_end) begin
            walker_x <= nbr_x[dir_q][CW-1:0];
            walker_y <= nbr_y[dir_q][CW-1:0];
            if (push_ok) begin
              count <= count + NW'(1);
            end
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an active maze always has its start cell on the stack
  `MBC_ASSERT_IMP(a_live_stack, !finished, count != '0)
  // the grid is written only by the clearing pass and the carve
  `MBC_ASSERT_IMP(a_grid_wr_src, grid_we,
                  state == S_CLEAR || state == S_CARVE_HERE || state == S_CARVE_THERE)
  // a carve only ever enters a free on-grid neighbor
  `MBC_ASSERT_IMP(a_carve_free, state == S_CARVE_HERE, free[dir_q] && nbr_in[dir_q])
  // a pop never leaves the stack empty before the read of the new top
  `MBC_ASSERT_IMP(a_pop_nonempty, state == S_POP_WAIT, count != '0 && !finished)
  // one request in flight at a time
  `MBC_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the depth-first maze carver
// ----------------------------------------------------------------------------
// A short list of directed requests covers reset behavior, reads outside the
// grid, the unused request code, a one-cell maze, the end cell as a leaf and
// the largest grid. Random phases follow: each one may resize the grid and
// move the start and end columns, usually starts a fresh maze, and then
// offers mostly step requests with reads and odd codes mixed in. A behavioral
// copy of the carver predicts every result that the list does not fix, and a
// monitor checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mbc_pkg::*;

  localparam int ITEM_TARGET = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int CALM_TAIL   = 110;
  localparam int MAX_REPORTS = 10;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  mbc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  mbc_out_t out_data;
  logic     cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;

  maze_backtracker_carver u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // carver model state
  // --------------------------------------------------------------------------
  logic [WALL_W-1:0] wall_map [CELLS];
  logic [IDX_W-1:0]  trail [CELLS];
  int unsigned       trail_depth;
  int                walk_x, walk_y;
  bit                walk_done;
  logic [6:0]        reg_width, reg_height;
  logic [5:0]        reg_start, reg_end;

  mbc_out_t carve_results_due [$];
  int       bad_count;
  int       items_sent;
  int       hold_asked, hold_served;
  bit       tx_gaps, rx_gaps;

  // grid size as the block uses it: register clamped to 1..max
  function automatic int span_w();
    int v;
    v = reg_width;
    if (v < 1) v = 1;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return v;
  endfunction

  function automatic int span_h();
    int v;
    v = reg_height;
    if (v < 1) v = 1;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return v;
  endfunction

  function automatic int goal_x();
    return (int'(reg_end) < span_w()) ? int'(reg_end) : span_w() - 1;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < span_w() && y < span_h();
  endfunction

  function automatic int cell_at(int x, int y);
    return (y % MAX_HEIGHT) * MAX_WIDTH + (x % MAX_WIDTH);
  endfunction

  function automatic int move_dx(dir_t d);
    case (d)
      DIR_LEFT:  return -1;
      DIR_RIGHT: return 1;
      default:   return 0;
    endcase
  endfunction

  function automatic int move_dy(dir_t d);
    case (d)
      DIR_DOWN: return 1;
      DIR_UP:   return -1;
      default:  return 0;
    endcase
  endfunction

  // side opened in the cell being left
  function automatic logic [WALL_W-1:0] exit_side(dir_t d);
    case (d)
      DIR_LEFT:  return 4'b1000;
      DIR_DOWN:  return 4'b0001;
      DIR_RIGHT: return 4'b0010;
      default:   return 4'b0100;
    endcase
  endfunction

  // side opened in the cell being entered
  function automatic logic [WALL_W-1:0] entry_side(dir_t d);
    case (d)
      DIR_LEFT:  return 4'b0010;
      DIR_DOWN:  return 4'b0100;
      DIR_RIGHT: return 4'b1000;
      default:   return 4'b0001;
    endcase
  endfunction

  // the end cell never counts as a branch point
  function automatic bit has_fresh_neighbor(int x, int y);
    int d, nx, ny;
    if (x == goal_x() && y == 0) return 1'b0;
    for (d = 0; d < 4; d++) begin
      nx = x + move_dx(dir_t'(d));
      ny = y + move_dy(dir_t'(d));
      if (on_grid(nx, ny) && wall_map[cell_at(nx, ny)] == '0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mbc_out_t make_outcome(status_t st, int x, int y,
                                            logic [WALL_W-1:0] w);
    mbc_out_t r;
    r.status     = st;
    r.pos_x      = COORD_W'(x);
    r.pos_y      = COORD_W'(y);
    r.walls      = w;
    r.path_depth = COUNT_W'(trail_depth);
    return r;
  endfunction

  // advance the model by one accepted request and return its result
  function automatic mbc_out_t carve_model_step(mbc_in_t req);
    int nx, ny, here, there, e;
    case (req.req_type)
      REQ_START: begin
        foreach (wall_map[i]) wall_map[i] = '0;
        walk_x = (int'(reg_start) < span_w()) ? int'(reg_start) : span_w() - 1;
        walk_y = span_h() - 1;
        trail[0] = IDX_W'(cell_at(walk_x, walk_y));
        trail_depth = 1;
        walk_done = 1'b0;
        return make_outcome(ST_STARTED, walk_x, walk_y, '0);
      end
      REQ_READ: begin
        return make_outcome(ST_READ, req.cell_x, req.cell_y,
                            on_grid(req.cell_x, req.cell_y) ?
                            wall_map[cell_at(req.cell_x, req.cell_y)] : '0);
      end
      REQ_NONE: begin
        return make_outcome(ST_REJECTED, walk_x, walk_y,
                            wall_map[cell_at(walk_x, walk_y)]);
      end
      default: begin
        // unwind the path until the walker sits next to an unvisited cell
        while (!walk_done && !has_fresh_neighbor(walk_x, walk_y)) begin
          if (trail_depth > 0) trail_depth--;
          if (trail_depth == 0) begin
            walk_done = 1'b1;
          end else begin
            e = trail[(trail_depth - 1) % CELLS];
            walk_x = e % MAX_WIDTH;
            walk_y = e / MAX_WIDTH;
          end
        end
        here = cell_at(walk_x, walk_y);
        if (walk_done) return make_outcome(ST_FINISHED, walk_x, walk_y, wall_map[here]);
        nx = walk_x + move_dx(req.direction);
        ny = walk_y + move_dy(req.direction);
        if (!on_grid(nx, ny) || wall_map[cell_at(nx, ny)] != '0)
          return make_outcome(ST_REJECTED, walk_x, walk_y, wall_map[here]);
        there = cell_at(nx, ny);
        wall_map[here]  |= exit_side(req.direction);
        wall_map[there] |= entry_side(req.direction);
        // the end cell is carved into but the walker does not move there
        if (!(nx == goal_x() && ny == 0)) begin
          if (trail_depth < CELLS) begin
            trail[trail_depth] = IDX_W'(there);
            trail_depth++;
          end
          walk_x = nx;
          walk_y = ny;
        end
        return make_outcome(ST_CARVED, walk_x, walk_y, wall_map[cell_at(walk_x, walk_y)]);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // directed requests
  // --------------------------------------------------------------------------
  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    cfg_reg_t   reg_sel;
    int         reg_val;
    mbc_in_t    req;
    bit         known;
    mbc_out_t   want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_req(req_t t, dir_t d, int x, int y);
    plan_row_t row;
    row.kind = ROW_REQ;
    row.reg_sel = CFG_WIDTH;
    row.reg_val = 0;
    row.req.req_type  = t;
    row.req.direction = d;
    row.req.cell_x    = COORD_W'(x);
    row.req.cell_y    = COORD_W'(y);
    row.known = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  // request whose result is plain from the spec
  function automatic void plan_known(req_t t, dir_t d, int x, int y,
                                     status_t st, int px, int py, int w, int dp);
    plan_req(t, d, x, y);
    plan[$].known = 1'b1;
    plan[$].want.status     = st;
    plan[$].want.pos_x      = COORD_W'(px);
    plan[$].want.pos_y      = COORD_W'(py);
    plan[$].want.walls      = WALL_W'(w);
    plan[$].want.path_depth = COUNT_W'(dp);
  endfunction

  function automatic void plan_cfg(cfg_reg_t r, int v);
    plan_row_t row;
    row = '{kind: ROW_CFG, reg_sel: r, reg_val: v, req: '0, known: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  task automatic send(input mbc_in_t req, input bit known, input mbc_out_t want);
    mbc_out_t guess;
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge
    guess = carve_model_step(req);
    carve_results_due.push_back(known ? want : guess);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (carve_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= SIZE_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (r)
      CFG_WIDTH:  reg_width  = 7'(v);
      CFG_HEIGHT: reg_height = 7'(v);
      CFG_START:  reg_start  = 6'(v);
      default:    reg_end    = 6'(v);
    endcase
  endtask

  function automatic mbc_in_t draw_request();
    mbc_in_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.direction = dir_t'($urandom_range(0, 3));
    r.cell_x    = COORD_W'($urandom);
    r.cell_y    = COORD_W'($urandom);
    if (pick < 4) begin
      r.req_type = REQ_START;
    end else if (pick < 16) begin
      r.req_type = REQ_READ;
      // most reads land on the live grid, the rest anywhere
      if (pick < 13) begin
        r.cell_x = COORD_W'($urandom_range(0, span_w() - 1));
        r.cell_y = COORD_W'($urandom_range(0, span_h() - 1));
      end
    end else if (pick < 19) begin
      r.req_type = REQ_NONE;
    end else begin
      r.req_type = REQ_STEP;
    end
    return r;
  endfunction

  // grid sizes: mostly small so mazes finish, now and then raw extremes
  task automatic pick_config(input bit all_regs);
    int w, h, sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end else if (sel < 8) begin
      w = $urandom_range(9, 24);
      h = $urandom_range(9, 24);
    end else if (sel == 8) begin
      w = $urandom_range(0, 127);
      h = $urandom_range(0, 127);
    end else begin
      w = ($urandom_range(0, 1) == 0) ? 0 : 127;
      h = ($urandom_range(0, 1) == 0) ? 1 : 64;
    end
    if (all_regs || $urandom_range(0, 9) < 7) write_reg(CFG_WIDTH, w);
    if (all_regs || $urandom_range(0, 9) < 7) write_reg(CFG_HEIGHT, h);
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(CFG_START, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, span_w()));
    if (all_regs || $urandom_range(0, 9) < 7)
      write_reg(CFG_END, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, span_w()));
  endtask

  // --------------------------------------------------------------------------
  // receiver side: random stalls, plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : ready_driver
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_asked) begin
        // long hold so the output register fills and input backs up
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic check_result(input mbc_out_t got);
    mbc_out_t e;
    if (carve_results_due.size() == 0) begin
      bad_count++;
      if (bad_count <= MAX_REPORTS)
        $display("unexpected result: status %0d pos (%0d,%0d) walls %b depth %0d",
                 got.status, got.pos_x, got.pos_y, got.walls, got.path_depth);
      return;
    end
    e = carve_results_due.pop_front();
    if (got.status !== e.status || got.pos_x !== e.pos_x || got.pos_y !== e.pos_y ||
        got.walls !== e.walls || got.path_depth !== e.path_depth) begin
      bad_count++;
      if (bad_count <= MAX_REPORTS)
        $display("mismatch: expected status %0d pos (%0d,%0d) walls %b depth %0d, got status %0d pos (%0d,%0d) walls %b depth %0d",
                 e.status, e.pos_x, e.pos_y, e.walls, e.path_depth,
                 got.status, got.pos_x, got.pos_y, got.walls, got.path_depth);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase, n;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_wdata = '0;
    bad_count = 0;
    items_sent = 0;
    hold_asked = 0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    reg_width = 7'd16;
    reg_height = 7'd16;
    reg_start = 6'd0;
    reg_end = 6'd15;
    foreach (wall_map[i]) wall_map[i] = '0;
    trail_depth = 0;
    walk_x = 0;
    walk_y = 0;
    walk_done = 1'b1;

    // reset state: no maze yet
    plan_known(REQ_STEP, DIR_RIGHT, 0, 0, ST_FINISHED, 0, 0, 0, 0);
    plan_known(REQ_READ, DIR_LEFT, 0, 0, ST_READ, 0, 0, 0, 0);
    plan_known(REQ_READ, DIR_UP, 63, 63, ST_READ, 63, 63, 0, 0);
    plan_known(REQ_NONE, DIR_DOWN, 5, 9, ST_REJECTED, 0, 0, 0, 0);
    // 16 x 16 maze from the bottom left corner
    plan_known(REQ_START, DIR_LEFT, 0, 0, ST_STARTED, 0, 15, 0, 1);
    plan_req(REQ_STEP, DIR_UP, 0, 0);
    plan_req(REQ_STEP, DIR_LEFT, 0, 0);
    plan_req(REQ_STEP, DIR_DOWN, 0, 0);
    plan_req(REQ_STEP, DIR_RIGHT, 0, 0);
    plan_req(REQ_STEP, DIR_DOWN, 0, 0);
    plan_req(REQ_STEP, DIR_LEFT, 0, 0);
    plan_req(REQ_READ, DIR_LEFT, 0, 14);
    plan_req(REQ_READ, DIR_RIGHT, 63, 0);
    // single cell: start is the end cell, first step finishes
    plan_cfg(CFG_WIDTH, 1);
    plan_cfg(CFG_HEIGHT, 1);
    plan_known(REQ_START, DIR_UP, 0, 0, ST_STARTED, 0, 0, 0, 1);
    plan_known(REQ_STEP, DIR_UP, 0, 0, ST_FINISHED, 0, 0, 0, 0);
    plan_known(REQ_STEP, DIR_RIGHT, 0, 0, ST_FINISHED, 0, 0, 0, 0);
    // two cells in a row: carving into the end cell leaves the walker put
    plan_cfg(CFG_WIDTH, 2);
    plan_cfg(CFG_START, 63);
    plan_cfg(CFG_END, 0);
    plan_known(REQ_START, DIR_DOWN, 0, 0, ST_STARTED, 1, 0, 0, 1);
    plan_req(REQ_STEP, DIR_LEFT, 0, 0);
    plan_req(REQ_STEP, DIR_UP, 0, 0);
    // largest grid, raw register values above the clamp
    plan_cfg(CFG_WIDTH, 127);
    plan_cfg(CFG_HEIGHT, 127);
    plan_cfg(CFG_END, 63);
    plan_known(REQ_START, DIR_DOWN, 0, 0, ST_STARTED, 63, 63, 0, 1);
    plan_req(REQ_STEP, DIR_UP, 0, 0);
    plan_req(REQ_STEP, DIR_RIGHT, 0, 0);
    plan_req(REQ_READ, DIR_DOWN, 63, 63);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_results();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send(plan[i].req, plan[i].known, plan[i].want);
      end
    end

    // random phases; the last stretch runs with no random gaps on either side
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_results();
      pick_config(phase == 0);
      if (items_sent + CALM_TAIL >= ITEM_TARGET) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end
      if (phase == 1) hold_asked++;
      // sometimes keep the old maze under the new size
      if ($urandom_range(0, 9) < 8) send('{REQ_START, DIR_LEFT, 6'd0, 6'd0}, 1'b0, '0);
      n = $urandom_range(20, 60);
      repeat (n) send(draw_request(), 1'b0, '0);
      phase++;
    end

    settle_results();
    repeat (100) @(posedge clk);
    if (bad_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
